// ===== sv/nectx_pkg.sv =====
// Shared types, register map and constants for the NEC IR frame transmitter.
// No dependencies; every other file but nectx_if imports this package.
package nectx_pkg;

  // Frame and register geometry.
  localparam int FRAME_BITS = 32;
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 16;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int DATA_W     = 32;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_PRO_ON   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRO_OFF  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ONE_ON   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ONE_OFF  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ZERO_ON  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_ZERO_OFF = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_EPI_ON   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_EPI_OFF  = IDX_W'(7);

  // Input command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Register file contents, one 16-bit tick count per entry.
  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  // Reset values, entry 0 in the lowest slice.
  localparam cfg_regs_t REG_RESET = {
    16'd0,    // epilogue off
    16'd562,  // epilogue on
    16'd562,  // zero off
    16'd562,  // zero on
    16'd1687, // one off
    16'd562,  // one on
    16'd4500, // prologue off
    16'd9000  // prologue on
  };

  // Frame phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRO,
    PH_DATA,
    PH_EPI
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic        command;
    logic [31:0] frame_code;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic carrier_enable;
    logic busy_res;
    logic frame_done;
  } res_t;

  // Status of the sequencer as seen by the top level.
  typedef struct packed {
    logic busy;
    logic in_off_half;
  } core_stat_t;

endpackage

// ===== sv/nectx_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Field widths follow the transmitter's item and result layout.
interface nectx_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] frame_code;

  modport source (output valid, output command, output frame_code, input ready);
  modport sink   (input valid, input command, input frame_code, output ready);
endinterface

interface nectx_out_if;
  logic valid;
  logic ready;
  logic carrier_enable;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output carrier_enable, output busy_res,
                  output frame_done, input ready);
  modport sink   (input valid, input carrier_enable, input busy_res,
                  input frame_done, output ready);
endinterface

// ===== sv/nectx_regs.sv =====
// APB-style register file holding the eight burst timing registers.
// Depends on nectx_pkg for the register map and reset values.
module nectx_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nectx_pkg::ADDR_W-1:0] paddr,
  input  logic [nectx_pkg::DATA_W-1:0] pwdata,
  output logic [nectx_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output nectx_pkg::cfg_regs_t      cfg
);
  import nectx_pkg::*;

  cfg_regs_t        regs_r;
  cfg_regs_t        regs_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // The access phase completes at once.
  assign pready = 1'b1;

  // Write decode.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      regs_nxt[idx] = pwdata[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REG_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read data, zero extended.
  assign prdata = {{(DATA_W-REG_W){1'b0}}, regs_r[idx]};
  assign cfg    = regs_r;

endmodule

// ===== sv/nectx_core.sv =====
// Frame sequencer: phase, half and tick counters, and zero-length skipping.
// Depends on nectx_pkg for the phase type, register map and item types.
module nectx_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  nectx_pkg::item_t      item,
  input  nectx_pkg::cfg_regs_t  cfg,
  output nectx_pkg::res_t       res,
  output nectx_pkg::core_stat_t stat
);
  import nectx_pkg::*;

  // Sequencer state. Data bits are kept in reverse order, and the pending
  // vector marks the bits not yet reached. Whether a bit takes any time is
  // decided from the current registers, so the next bit to send is the
  // lowest pending bit whose halves are not both empty.
  phase_t                phase_r,   phase_nxt;
  logic                  off_r,     off_nxt;
  logic [REG_W-1:0]      elapsed_r, elapsed_nxt;
  logic                  val_r,     val_nxt;
  logic [FRAME_BITS-1:0] pend_r,    pend_nxt;
  logic [FRAME_BITS-1:0] code_r,    code_nxt;

  logic [NUM_REGS-1:0]   zero;
  logic                  empty_one;
  logic                  empty_zero;
  logic [FRAME_BITS-1:0] rev_in;
  logic [FRAME_BITS-1:0] ne_in;
  logic [FRAME_BITS-1:0] ne_cur;
  logic                  is_start;
  logic [FRAME_BITS-1:0] src_pend;
  logic [FRAME_BITS-1:0] src_rem;
  logic [FRAME_BITS-1:0] src_code;
  logic [FRAME_BITS-1:0] first_bit;
  logic [FRAME_BITS-1:0] low_mask;
  logic [FRAME_BITS-1:0] pend_after;
  logic                  data_any;
  logic                  first_val;
  logic [IDX_W-1:0]      base_idx;
  logic [IDX_W-1:0]      half_idx;
  logic [REG_W-1:0]      half_len;
  logic [REG_W:0]        elapsed_inc;
  logic                  expire;
  logic                  zero_off_cur;
  logic                  zero_on_first;
  logic                  done_c;
  logic                  want_data;
  logic                  want_epi;
  logic                  want_end;

  // Zero-length flags for every register.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      zero[i] = (cfg[i] == '0);
    end
  end

  // A data bit is skipped entirely when both of its halves are empty.
  assign empty_one  = zero[REG_ONE_ON]  && zero[REG_ONE_OFF];
  assign empty_zero = zero[REG_ZERO_ON] && zero[REG_ZERO_OFF];

  // Reverse the code on start and mark the bits that take any time, both for
  // the new code and for the stored one.
  always_comb begin
    for (int k = 0; k < FRAME_BITS; k++) begin
      rev_in[k] = item.frame_code[FRAME_BITS-1-k];
      ne_in[k]  = rev_in[k] ? !empty_one : !empty_zero;
      ne_cur[k] = code_r[k] ? !empty_one : !empty_zero;
    end
  end

  assign is_start = (item.command == CMD_START);

  // Next non-empty data bit, from the new code on start, else from the stored one.
  assign src_pend      = is_start ? ne_in  : (pend_r & ne_cur);
  assign src_rem       = is_start ? {FRAME_BITS{1'b1}} : pend_r;
  assign src_code      = is_start ? rev_in : code_r;
  assign first_bit     = src_pend & ((~src_pend) + {{(FRAME_BITS-1){1'b0}}, 1'b1});
  assign low_mask      = src_pend ^ (src_pend - {{(FRAME_BITS-1){1'b0}}, 1'b1});
  assign pend_after    = src_rem & ~low_mask;
  assign data_any      = |src_pend;
  assign first_val     = |(first_bit & src_code);
  assign zero_on_first = first_val ? zero[REG_ONE_ON] : zero[REG_ZERO_ON];
  assign zero_off_cur  = val_r ? zero[REG_ONE_OFF] : zero[REG_ZERO_OFF];

  // Length of the half now being sent.
  always_comb begin
    case (phase_r)
      PH_PRO:  base_idx = REG_PRO_ON;
      PH_DATA: base_idx = val_r ? REG_ONE_ON : REG_ZERO_ON;
      default: base_idx = REG_EPI_ON;
    endcase
  end

  assign half_idx    = base_idx | {{(IDX_W-1){1'b0}}, off_r};
  assign half_len    = cfg[half_idx];
  assign elapsed_inc = {1'b0, elapsed_r} + {{REG_W{1'b0}}, 1'b1};
  assign expire      = (elapsed_inc >= {1'b0, half_len});

  // Next state: advance one half on expiry, then fall through empty halves
  // into the data bits, the epilogue and the end of the frame.
  always_comb begin
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    elapsed_nxt = elapsed_r;
    val_nxt     = val_r;
    pend_nxt    = pend_r;
    code_nxt    = code_r;
    done_c      = 1'b0;
    want_data   = 1'b0;
    want_epi    = 1'b0;
    want_end    = 1'b0;

    if (step_en) begin
      if (is_start) begin
        if (phase_r == PH_IDLE) begin
          phase_nxt   = PH_PRO;
          off_nxt     = 1'b0;
          elapsed_nxt = '0;
          code_nxt    = rev_in;
          pend_nxt    = {FRAME_BITS{1'b1}};
          if (zero[REG_PRO_ON]) begin
            if (!zero[REG_PRO_OFF]) begin
              off_nxt = 1'b1;
            end else begin
              want_data = 1'b1;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if (!expire) begin
          elapsed_nxt = elapsed_inc[REG_W-1:0];
        end else begin
          elapsed_nxt = '0;
          case (phase_r)
            PH_PRO: begin
              if (!off_r && !zero[REG_PRO_OFF]) off_nxt = 1'b1;
              else want_data = 1'b1;
            end
            PH_DATA: begin
              if (!off_r && !zero_off_cur) off_nxt = 1'b1;
              else want_data = 1'b1;
            end
            PH_EPI: begin
              if (!off_r && !zero[REG_EPI_OFF]) off_nxt = 1'b1;
              else want_end = 1'b1;
            end
            default: begin
              want_end = 1'b0;
            end
          endcase
        end
      end

      // Enter the next data bit that takes any time, or go to the epilogue.
      if (want_data) begin
        if (data_any) begin
          phase_nxt = PH_DATA;
          val_nxt   = first_val;
          off_nxt   = zero_on_first;
          pend_nxt  = pend_after;
        end else begin
          want_epi = 1'b1;
        end
      end

      // Enter the epilogue, skipping empty halves.
      if (want_epi) begin
        phase_nxt = PH_EPI;
        if (!zero[REG_EPI_ON]) begin
          off_nxt = 1'b0;
        end else if (!zero[REG_EPI_OFF]) begin
          off_nxt = 1'b1;
        end else begin
          want_end = 1'b1;
        end
      end

      // Frame complete.
      if (want_end) begin
        phase_nxt = PH_IDLE;
        off_nxt   = 1'b0;
        done_c    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      off_r     <= 1'b0;
      elapsed_r <= '0;
      val_r     <= 1'b0;
      pend_r    <= '0;
      code_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      elapsed_r <= elapsed_nxt;
      val_r     <= val_nxt;
      pend_r    <= pend_nxt;
      code_r    <= code_nxt;
    end
  end

  // Result fields reflect the state after this transaction.
  always_comb begin
    res.carrier_enable = (phase_nxt != PH_IDLE) && !off_nxt;
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.frame_done     = done_c;
    stat.busy          = (phase_r != PH_IDLE);
    stat.in_off_half   = off_r;
  end

endmodule

// ===== sv/nec_ir_frame_transmitter.sv =====
// Top level of the NEC IR frame transmitter: input register, sequencer,
// result register and timing registers. Depends on nectx_pkg, nectx_if,
// nectx_regs and nectx_core.
//
//  Channel   Direction  Handshake             Payload
//  in_chan   sink       valid/ready           command, frame_code
//  out_chan  source     valid/ready           carrier_enable, busy_res, frame_done
//  cfg_*     slave      APB setup + access    eight 16-bit tick registers
//
// One transaction per cycle is sustained while out_chan.ready stays high; a result
// is presented once its input transaction has passed the input register and then
// the sequencer step that loads the result register.
// A stalled result register holds the sequencer, and the input register then
// fills and drops in_chan.ready.
// rst_n is synchronous and active low; it restores the register reset values
// and idles the sequencer.
module nec_ir_frame_transmitter (
  input  logic                         clk,
  input  logic                         rst_n,
  nectx_in_if.sink                     in_chan,
  nectx_out_if.source                  out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [nectx_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [nectx_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [nectx_pkg::DATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import nectx_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  item_t      s1_item_r,  s1_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r,   out_res_nxt;
  logic       in_fire;
  logic       s2_fire;
  cfg_regs_t  cfg;
  res_t       core_res;
  core_stat_t core_stat;

  // Timing registers.
  nectx_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Handshakes: the sequencer steps whenever the result register can take a value.
  assign s2_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s2_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_fire) begin
      s1_valid_nxt          = 1'b1;
      s1_item_nxt.command    = in_chan.command;
      s1_item_nxt.frame_code = in_chan.frame_code;
    end else if (s2_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Sequencer.
  nectx_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s2_fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (core_res),
    .stat    (core_stat)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = core_res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.carrier_enable = out_res_r.carrier_enable;
  assign out_chan.busy_res       = out_res_r.busy_res;
  assign out_chan.frame_done     = out_res_r.frame_done;

  // A step that ends the frame leaves the sequencer idle.
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && core_res.frame_done) |=> !core_stat.busy)
    else $error("sequencer still busy after frame end");

  // Every sequencer step produces a pending result on the next cycle.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> out_valid_r)
    else $error("sequencer step lost its result");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a result stall");

  // The carrier is never on while no frame is being sent.
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |-> !(core_res.carrier_enable && !core_res.busy_res))
    else $error("carrier enabled while idle");

endmodule

// ===== test/tb_nec_ir_frame_transmitter.sv =====
// Self-checking testbench for the NEC IR frame transmitter: directed table, then random phases.
// Depends on nectx_pkg, nectx_if and nec_ir_frame_transmitter; the predictor lives in this file.
`timescale 1ns / 1ps

module tb_nec_ir_frame_transmitter;
  import nectx_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RAND_ITEMS = 1950;
  localparam int LIMIT_NS   = 10_000_000;

  // One row of the directed table: a register write or an input transaction.
  typedef struct {
    bit                   is_cfg;
    logic [IDX_W-1:0]     reg_idx;
    logic [REG_W-1:0]     reg_val;
    logic                 command;
    logic [31:0]          code;
    bit                   typed;
    res_t                 want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  nectx_in_if  in_chan ();
  nectx_out_if out_chan ();

  nec_ir_frame_transmitter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted transmitter state and timing registers.
  phase_t           tx_phase;
  logic             tx_off_half;
  logic [15:0]      tx_elapsed;
  logic [5:0]       tx_bits_left;
  logic [31:0]      tx_shift;
  logic [REG_W-1:0] tick_len [NUM_REGS];

  res_t pending_outputs [$];
  int   fail_count = 0;
  bit   no_idle    = 1'b0;

  // Length of the half now being sent.
  function automatic logic [REG_W-1:0] cur_half_len();
    logic [IDX_W-1:0] idx;
    if (tx_phase == PH_PRO) begin
      idx = REG_PRO_ON;
    end else if (tx_phase == PH_DATA) begin
      idx = tx_shift[31] ? REG_ONE_ON : REG_ZERO_ON;
    end else begin
      idx = REG_EPI_ON;
    end
    idx[0] = tx_off_half;
    return tick_len[idx];
  endfunction

  // Advance to the next half; returns 1 when the frame has ended.
  function automatic bit next_half();
    tx_elapsed = '0;
    if (!tx_off_half) begin
      tx_off_half = 1'b1;
      return 1'b0;
    end
    tx_off_half = 1'b0;
    case (tx_phase)
      PH_PRO: begin
        tx_phase = (tx_bits_left != 0) ? PH_DATA : PH_EPI;
      end
      PH_DATA: begin
        tx_shift     = tx_shift << 1;
        tx_bits_left = tx_bits_left - 6'd1;
        if (tx_bits_left == 0) tx_phase = PH_EPI;
      end
      default: begin
        tx_phase     = PH_IDLE;
        tx_bits_left = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Pass over halves of zero length; returns 1 when the frame ended on the way.
  function automatic bit skip_empty_halves();
    bit done;
    done = 1'b0;
    while (tx_phase != PH_IDLE && cur_half_len() == 0) begin
      if (next_half()) done = 1'b1;
    end
    return done;
  endfunction

  // Apply one input transaction to the predicted state and return its outputs.
  function automatic res_t next_frame_outputs(logic cmd, logic [31:0] code);
    res_t        r;
    bit          done;
    logic [16:0] e;
    done = 1'b0;
    if (cmd == CMD_START) begin
      if (tx_phase == PH_IDLE) begin
        tx_shift     = code << (32 - FRAME_BITS);
        tx_bits_left = 6'(FRAME_BITS);
        tx_phase     = PH_PRO;
        tx_off_half  = 1'b0;
        tx_elapsed   = '0;
        done         = skip_empty_halves();
      end
    end else if (tx_phase != PH_IDLE) begin
      e = {1'b0, tx_elapsed} + 17'd1;
      if (e >= {1'b0, cur_half_len()}) begin
        if (next_half()) done = 1'b1;
        if (skip_empty_halves()) done = 1'b1;
      end else begin
        tx_elapsed = e[15:0];
      end
    end
    r.carrier_enable = (tx_phase != PH_IDLE) && !tx_off_half;
    r.busy_res       = (tx_phase != PH_IDLE);
    r.frame_done     = done;
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Tick lengths: mostly tiny or zero, sometimes the maximum or anything.
  function automatic logic [REG_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'hFFFF;
    if (r < 7) return REG_W'($urandom_range(0, 65535));
    if (r < 32) return '0;
    return REG_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [31:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic step_t mk_item(logic cmd, logic [31:0] code, bit typed, res_t want);
    step_t s;
    s = '{default: '0};
    s.command = cmd;
    s.code    = code;
    s.typed   = typed;
    s.want    = want;
    return s;
  endfunction

  function automatic step_t mk_cfg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Lower valid and wait until every expected result has been received.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Drive one input transaction; called and left at a falling edge.
  task automatic send_item(logic cmd, logic [31:0] code, bit typed, res_t want);
    res_t pred;
    int   gap;
    in_chan.valid      <= 1'b1;
    in_chan.command    <= cmd;
    in_chan.frame_code <= code;
    do @(posedge clk); while (!in_chan.ready);
    pred = next_frame_outputs(cmd, code);
    pending_outputs.push_back(typed ? want : pred);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write one timing register with the pipeline empty, then read it back.
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(DATA_W - REG_W){1'b0}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tick_len[idx] = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_psel <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(DATA_W - REG_W){1'b0}}, tick_len[idx]}) begin
      $error("cfg_prdata[%0d]: expected %0h, actual %0h", idx, tick_len[idx], cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result checker: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_chan.carrier_enable !== want.carrier_enable) begin
          $error("carrier_enable: expected %0b, actual %0b",
                 want.carrier_enable, out_chan.carrier_enable);
          fail_count++;
        end
        if (out_chan.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, actual %0b", want.busy_res, out_chan.busy_res);
          fail_count++;
        end
        if (out_chan.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0b, actual %0b", want.frame_done, out_chan.frame_done);
          fail_count++;
        end
      end
    end
  end

  // Receiver with random back-pressure.
  initial begin
    int stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          out_chan.ready <= 1'b0;
          stall_left--;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    step_t dir_steps [$];
    int    rand_items;
    int    phase_items;
    logic  cmd;

    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_TICK;
    in_chan.frame_code = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;

    // Predictor reset.
    tx_phase     = PH_IDLE;
    tx_off_half  = 1'b0;
    tx_elapsed   = '0;
    tx_bits_left = '0;
    tx_shift     = '0;
    for (int i = 0; i < NUM_REGS; i++) tick_len[i] = REG_RESET[i];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; result order is carrier_enable, busy_res, frame_done.
    dir_steps.push_back(mk_item(CMD_TICK,  32'h0, 1, res_t'(3'b000)));    // tick while idle
    dir_steps.push_back(mk_item(CMD_START, 32'hFFFF_FFFF, 1, res_t'(3'b110)));
    dir_steps.push_back(mk_item(CMD_START, 32'h0, 1, res_t'(3'b110)));    // start while busy
    dir_steps.push_back(mk_item(CMD_TICK,  32'hFFFF_FFFF, 1, res_t'(3'b110)));
    // Shrink the running half below its elapsed count: it ends on the next tick.
    dir_steps.push_back(mk_cfg(REG_PRO_ON, 16'd0));
    dir_steps.push_back(mk_item(CMD_TICK,  32'h0, 1, res_t'(3'b010)));
    // Every remaining half empty: the frame ends within one tick.
    dir_steps.push_back(mk_cfg(REG_PRO_OFF,  16'd0));
    dir_steps.push_back(mk_cfg(REG_ONE_ON,   16'd0));
    dir_steps.push_back(mk_cfg(REG_ONE_OFF,  16'd0));
    dir_steps.push_back(mk_cfg(REG_ZERO_ON,  16'd0));
    dir_steps.push_back(mk_cfg(REG_ZERO_OFF, 16'd0));
    dir_steps.push_back(mk_cfg(REG_EPI_ON,   16'd0));
    dir_steps.push_back(mk_item(CMD_TICK,  32'h0, 1, res_t'(3'b001)));
    dir_steps.push_back(mk_item(CMD_TICK,  32'h0, 1, res_t'(3'b000)));
    // A frame made only of empty halves ends on the start transaction itself.
    dir_steps.push_back(mk_item(CMD_START, 32'h1234_5678, 1, res_t'(3'b001)));
    dir_steps.push_back(mk_cfg(REG_ONE_ON,   16'd1));
    dir_steps.push_back(mk_cfg(REG_ZERO_OFF, 16'd2));
    dir_steps.push_back(mk_cfg(REG_EPI_OFF,  16'hFFFF));
    dir_steps.push_back(mk_item(CMD_START, 32'hA5A5_A5A5, 0, '0));
    for (int i = 0; i < 10; i++) dir_steps.push_back(mk_item(CMD_TICK, $urandom, 0, '0));
    dir_steps.push_back(mk_item(CMD_START, 32'h0000_0001, 0, '0));
    dir_steps.push_back(mk_cfg(REG_PRO_ON, 16'hFFFF));

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        cfg_write(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        send_item(dir_steps[i].command, dir_steps[i].code, dir_steps[i].typed,
                  dir_steps[i].want);
      end
    end

    // Random phases: new timings, then mostly well-formed frames with some noise.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      no_idle = 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        if ($urandom_range(0, 9) < 6) cfg_write(IDX_W'(r), pick_len());
      end
      no_idle     = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(60, 200);
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        if (tx_phase == PH_IDLE) begin
          cmd = ($urandom_range(0, 9) < 7) ? CMD_START : CMD_TICK;
        end else begin
          cmd = ($urandom_range(0, 99) < 8) ? CMD_START : CMD_TICK;
        end
        send_item(cmd, pick_code(), 0, '0);
        rand_items++;
      end
    end

    // Let every result arrive, then a short settle time.
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/nectx_pkg.sv
sv/nectx_if.sv
sv/nectx_regs.sv
sv/nectx_core.sv
sv/nec_ir_frame_transmitter.sv
test/tb_nec_ir_frame_transmitter.sv
